// ===== design/nsfc_pkg.sv =====
// Package for the NMEA sentence framer and checksum checker.
// Holds the byte codes, the token and result types and the hex decoder.
// No dependencies; every other design file imports it.
package nsfc_pkg;

   localparam int MAX_SENTENCE_LEN = 128;
   localparam int CNT_W            = $clog2(MAX_SENTENCE_LEN);
   localparam int LEN_W            = 7;
   localparam int TOKQ_DEPTH       = 2;
   localparam int TOKQ_PTR_W       = $clog2(TOKQ_DEPTH);
   localparam int TOKQ_CNT_W       = $clog2(TOKQ_DEPTH + 1);

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   typedef enum logic [2:0] {
      KIND_DOLLAR,
      KIND_CR,
      KIND_LF,
      KIND_STAR,
      KIND_NUL,
      KIND_OTHER
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic        hex_ok;
      logic [3:0]  hex_val;
   } token_type;

   typedef struct packed {
      logic [LEN_W-1:0] sentence_length;
      logic             sum_present;
      logic             sum_match;
   } result_type;

   typedef enum logic {
      FR_IDLE,
      FR_COLLECT
   } frame_state_type;

   // Hex digit value in either case; bit 4 is set when the byte is a hex digit.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'b0_0000;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end
      return r;
   endfunction

endpackage

// ===== design/nsfc_front.sv =====
// Front end of the NMEA framer: classifies each received byte into a token
// and holds tokens in a two-entry queue for the back end. Uses nsfc_pkg.
module nsfc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_rx_byte,
   output logic                 tok_valid,
   input  logic                 tok_pop,
   output nsfc_pkg::token_type  tok_data
);
   import nsfc_pkg::*;

   token_type               tok_q_ff [TOKQ_DEPTH];
   logic [TOKQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [TOKQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [TOKQ_CNT_W-1:0]   cnt_ff, cnt_in;
   token_type               new_tok;
   logic [4:0]              hex;
   logic                    do_push;
   logic                    do_pop;

   always_comb begin
      hex = hex_decode(req_rx_byte);
      new_tok.data    = req_rx_byte;
      new_tok.hex_ok  = hex[4];
      new_tok.hex_val = hex[3:0];
      case (req_rx_byte)
         CHAR_DOLLAR: new_tok.kind = KIND_DOLLAR;
         CHAR_CR:     new_tok.kind = KIND_CR;
         CHAR_LF:     new_tok.kind = KIND_LF;
         CHAR_STAR:   new_tok.kind = KIND_STAR;
         CHAR_NUL:    new_tok.kind = KIND_NUL;
         default:     new_tok.kind = KIND_OTHER;
      endcase
   end

   assign req_full  = (cnt_ff == TOKQ_CNT_W'(TOKQ_DEPTH));
   assign tok_valid = (cnt_ff != '0);
   assign tok_data  = tok_q_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = tok_pop && tok_valid;

   always_comb begin
      wr_ptr_in = do_push ? TOKQ_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? TOKQ_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = TOKQ_CNT_W'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = TOKQ_CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         tok_q_ff[wr_ptr_ff] <= new_tok;
      end
   end

`ifndef SYNTH
   a_tokq_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= TOKQ_CNT_W'(TOKQ_DEPTH))
      else $error("token queue count out of range");

   a_tokq_ptr_even: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != TOKQ_CNT_W'(1)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("token queue pointers apart while empty or full");

   a_tokq_ptr_odd: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == TOKQ_CNT_W'(1)) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("token queue pointers equal with one entry");
`endif

endmodule

// ===== design/nsfc_back.sv =====
// Back end of the NMEA framer: runs the sentence framing and checksum state
// on each token and queues results in a two-entry output queue. Uses nsfc_pkg.
module nsfc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_valid,
   output logic                 tok_pop,
   input  nsfc_pkg::token_type  tok_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [nsfc_pkg::LEN_W-1:0] rsp_sentence_length,
   output logic                 rsp_sum_present,
   output logic                 rsp_sum_match
);
   import nsfc_pkg::*;

   frame_state_type   state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        xor_ff, xor_in;
   logic              star_ff, star_in;
   logic [1:0]        digits_ff, digits_in;
   logic [3:0]        high_ff, high_in;
   logic [3:0]        low_ff, low_in;
   logic              err_ff, err_in;
   logic              nul_ff, nul_in;

   result_type        out_q_ff [2];
   logic              out_wr_ff, out_wr_in;
   logic              out_rd_ff, out_rd_in;
   logic [1:0]        out_cnt_ff, out_cnt_in;

   logic              take;
   logic              at_limit;
   logic              res_push;
   logic              res_pop;
   logic              clear;
   result_type        res;

   // A token is taken whenever the output queue can absorb a possible result.
   assign tok_pop  = tok_valid && ((out_cnt_ff != 2'd2) || rsp_pop);
   assign take     = tok_pop;
   assign at_limit = (count_ff >= CNT_W'(MAX_SENTENCE_LEN - 1));

   // Next state of the framer.
   always_comb begin
      state_in = state_ff;
      if (take) begin
         case (state_ff)
            FR_IDLE: begin
               if (tok_data.kind == KIND_DOLLAR) begin
                  state_in = FR_COLLECT;
               end
            end
            FR_COLLECT: begin
               if (tok_data.kind == KIND_LF) begin
                  state_in = FR_IDLE;
               end else if (tok_data.kind != KIND_DOLLAR && tok_data.kind != KIND_CR
                            && at_limit) begin
                  state_in = FR_IDLE;
               end
            end
            default: state_in = FR_IDLE;
         endcase
      end
   end

   // Sentence datapath and result generation.
   always_comb begin
      count_in  = count_ff;
      xor_in    = xor_ff;
      star_in   = star_ff;
      digits_in = digits_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      err_in    = err_ff;
      nul_in    = nul_ff;
      res_push  = 1'b0;
      clear     = 1'b0;

      res.sum_present     = star_ff && (digits_ff == 2'd2) && !err_ff;
      res.sum_match       = !star_ff || (res.sum_present && (xor_ff == {high_ff, low_ff}));
      res.sentence_length = LEN_W'(count_ff);

      if (take) begin
         if (tok_data.kind == KIND_DOLLAR) begin
            clear    = 1'b1;
            count_in = CNT_W'(1);
         end else if (state_ff == FR_COLLECT && tok_data.kind != KIND_CR) begin
            if (tok_data.kind == KIND_LF) begin
               res_push = 1'b1;
               clear    = 1'b1;
            end else if (at_limit) begin
               clear    = 1'b1;
            end else begin
               count_in = CNT_W'(count_ff + 1'b1);
               if (nul_ff) begin
                  // The scan has ended; bytes are only counted.
               end else if (tok_data.kind == KIND_NUL) begin
                  nul_in = 1'b1;
               end else if (!star_ff) begin
                  if (tok_data.kind == KIND_STAR) begin
                     star_in = 1'b1;
                  end else begin
                     xor_in = xor_ff ^ tok_data.data;
                  end
               end else if (digits_ff != 2'd2) begin
                  if (!tok_data.hex_ok) begin
                     err_in = 1'b1;
                  end
                  if (digits_ff == 2'd0) begin
                     high_in = tok_data.hex_ok ? tok_data.hex_val : 4'h0;
                  end else begin
                     low_in  = tok_data.hex_ok ? tok_data.hex_val : 4'h0;
                  end
                  digits_in = 2'(digits_ff + 1'b1);
               end
            end
         end
      end

      if (clear) begin
         if (tok_data.kind != KIND_DOLLAR) begin
            count_in = '0;
         end
         xor_in    = '0;
         star_in   = 1'b0;
         digits_in = '0;
         high_in   = '0;
         low_in    = '0;
         err_in    = 1'b0;
         nul_in    = 1'b0;
      end
   end

   assign res_pop = rsp_pop && !rsp_empty;

   always_comb begin
      out_wr_in  = res_push ? ~out_wr_ff : out_wr_ff;
      out_rd_in  = res_pop  ? ~out_rd_ff : out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (res_push && !res_pop) begin
         out_cnt_in = 2'(out_cnt_ff + 1'b1);
      end else if (res_pop && !res_push) begin
         out_cnt_in = 2'(out_cnt_ff - 1'b1);
      end
   end

   assign rsp_empty           = (out_cnt_ff == 2'd0);
   assign rsp_sentence_length = out_q_ff[out_rd_ff].sentence_length;
   assign rsp_sum_present     = out_q_ff[out_rd_ff].sum_present;
   assign rsp_sum_match       = out_q_ff[out_rd_ff].sum_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FR_IDLE;
         count_ff   <= '0;
         xor_ff     <= '0;
         star_ff    <= 1'b0;
         digits_ff  <= '0;
         high_ff    <= '0;
         low_ff     <= '0;
         err_ff     <= 1'b0;
         nul_ff     <= 1'b0;
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         xor_ff     <= xor_in;
         star_ff    <= star_in;
         digits_ff  <= digits_in;
         high_ff    <= high_in;
         low_ff     <= low_in;
         err_ff     <= err_in;
         nul_ff     <= nul_in;
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         out_q_ff[out_wr_ff] <= res;
      end
   end

`ifndef SYNTH
   a_out_count_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= 2'd2)
      else $error("result queue count out of range");

   a_idle_is_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FR_IDLE) |-> (count_ff == '0 && !star_ff && xor_ff == 8'h00))
      else $error("framer state not cleared while idle");

   a_digits_need_star: assert property (@(posedge clock) disable iff (reset)
      !star_ff |-> (digits_ff == 2'd0 && !err_ff))
      else $error("checksum digits recorded without a star");

   a_result_from_lf: assert property (@(posedge clock) disable iff (reset)
      res_push |=> (state_ff == FR_IDLE && !rsp_empty))
      else $error("result pushed without closing the sentence");
`endif

endmodule

// ===== design/nmea_sentence_framer_checker.sv =====
// Top level of the NMEA sentence framer and checksum checker.
// Connects the classifying front end to the framing back end; uses nsfc_pkg.
//
//   channel   direction  handshake          payload
//   req_      in         req_push/req_full  req_rx_byte
//   rsp_      out        rsp_pop/rsp_empty  rsp_sentence_length, rsp_sum_present,
//                                           rsp_sum_match
//
// One byte is taken per cycle while req_full is low; a result is on the rsp_
// ports after its LF byte moves from the front token queue into the result queue.
// The front holds up to two classified bytes and the back up to two results,
// so each side stalls on its own; req_full rises when the front queue is full.
// Reset is synchronous and clears framing state and both queues.
module nmea_sentence_framer_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [nsfc_pkg::LEN_W-1:0]  rsp_sentence_length,
   output logic                        rsp_sum_present,
   output logic                        rsp_sum_match
);
   import nsfc_pkg::*;

   logic       tok_valid;
   logic       tok_pop;
   token_type  tok_data;

   nsfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .tok_valid   (tok_valid),
      .tok_pop     (tok_pop),
      .tok_data    (tok_data)
   );

   nsfc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .tok_valid           (tok_valid),
      .tok_pop             (tok_pop),
      .tok_data            (tok_data),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_sentence_length (rsp_sentence_length),
      .rsp_sum_present     (rsp_sum_present),
      .rsp_sum_match       (rsp_sum_match)
   );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the NMEA sentence framer and checksum checker.
// Streams bytes through the push side, predicts each sentence result and
// checks the results popped out; depends only on nsfc_pkg and the top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import nsfc_pkg::*;

   localparam int STALL_LIMIT  = 3000;
   localparam int RANDOM_BYTES = 1650;
   localparam int RX_HOLD_LEN  = 400;
   localparam int TAIL_CYCLES  = 20;

   typedef struct {
      logic [7:0] b;
      bit         drain_first;
   } stream_byte_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_push    = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_pop     = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [LEN_W-1:0] rsp_sentence_length;
   logic       rsp_sum_present;
   logic       rsp_sum_match;

   stream_byte_type byte_stream[$];
   result_type expected_sentences[$];

   bit req_xfer = 1'b0;
   bit rsp_xfer = 1'b0;
   int fail_count = 0;
   int stall_cycles = 0;
   int stream_total = 0;
   int tx_gap = 0, tx_burst = 0;
   int rx_gap = 0, rx_burst = 0, rx_hold = 0, rsp_count = 0;

   // Predictor state for the sentence being framed.
   bit         frame_open  = 1'b0;
   int         kept_count  = 0;
   logic [7:0] sum_xor     = 8'h00;
   bit         star_found  = 1'b0;
   int         digit_count = 0;
   logic [3:0] hi_digit    = 4'h0;
   logic [3:0] lo_digit    = 4'h0;
   bit         bad_digit   = 1'b0;
   bit         nul_seen    = 1'b0;

   nmea_sentence_framer_checker u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_rx_byte         (req_rx_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_sentence_length (rsp_sentence_length),
      .rsp_sum_present     (rsp_sum_present),
      .rsp_sum_match       (rsp_sum_match)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bit 4 is set when the byte is a hex digit in either case.
   function automatic logic [4:0] digit_value(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return {1'b1, b[3:0]};
      if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
         return {1'b1, 4'(b[3:0] + 4'd9)};
      return 5'b0_0000;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
   endfunction

   function automatic void clear_frame();
      frame_open  = 1'b0;
      kept_count  = 0;
      sum_xor     = 8'h00;
      star_found  = 1'b0;
      digit_count = 0;
      hi_digit    = 4'h0;
      lo_digit    = 4'h0;
      bad_digit   = 1'b0;
      nul_seen    = 1'b0;
   endfunction

   // Advances the framing state by one byte; returns 1 when a sentence closes.
   function automatic bit frame_byte(input logic [7:0] b, output result_type r);
      logic [4:0] d;
      r = '0;
      if (b == CHAR_DOLLAR) begin
         clear_frame();
         frame_open = 1'b1;
         kept_count = 1;
         return 1'b0;
      end
      if (!frame_open || b == CHAR_CR) return 1'b0;
      if (b == CHAR_LF) begin
         r.sentence_length = kept_count[LEN_W-1:0];
         r.sum_present     = 1'b0;
         r.sum_match       = 1'b1;
         if (star_found) begin
            if (digit_count >= 2 && !bad_digit) begin
               r.sum_present = 1'b1;
               r.sum_match   = (sum_xor == {hi_digit, lo_digit});
            end else begin
               r.sum_match = 1'b0;
            end
         end
         clear_frame();
         return 1'b1;
      end
      if (kept_count + 1 >= MAX_SENTENCE_LEN) begin
         clear_frame();
         return 1'b0;
      end
      kept_count++;
      // Once a zero byte has been seen, the rest is only counted.
      if (nul_seen) return 1'b0;
      if (b == CHAR_NUL) begin
         nul_seen = 1'b1;
         return 1'b0;
      end
      if (!star_found) begin
         if (b == CHAR_STAR) star_found = 1'b1;
         else sum_xor ^= b;
      end else if (digit_count < 2) begin
         d = digit_value(b);
         if (!d[4]) bad_digit = 1'b1;
         if (digit_count == 0) hi_digit = d[3:0];
         else lo_digit = d[3:0];
         digit_count++;
      end
      return 1'b0;
   endfunction

   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) burst = $urandom_range(20, 80);
      return $urandom_range(0, 9);
   endfunction

   task automatic add_byte(input logic [7:0] b, input bit drain_first = 1'b0);
      stream_byte_type s;
      s.b = b;
      s.drain_first = drain_first;
      byte_stream.push_back(s);
      stream_total++;
   endtask

   // A body byte that carries no framing meaning.
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == CHAR_DOLLAR || c == CHAR_STAR || c == CHAR_LF ||
                 c == CHAR_CR || c == CHAR_NUL);
      return c;
   endfunction

   task automatic add_sentence(input bit drain_first);
      int         n, sel;
      logic [7:0] x, c;
      bit         lower;
      sel = $urandom_range(0, 99);
      n = (sel < 4) ? $urandom_range(122, 128) : $urandom_range(0, 20);
      sel = (sel < 4) ? 0 : $urandom_range(0, 9);
      lower = 1'($urandom_range(0, 1));
      x = 8'h00;
      // Bytes before the dollar are ignored by an idle framer.
      if ($urandom_range(0, 9) == 0) add_byte(plain_byte());
      if ($urandom_range(0, 19) == 0) add_byte(CHAR_LF);
      add_byte(CHAR_DOLLAR, drain_first);
      if (sel == 9) begin
         // Raw noise; any byte, framing ones included.
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
         add_byte(CHAR_LF);
         return;
      end
      for (int i = 0; i < n; i++) begin
         if (sel == 7 && i == n / 2 && $urandom_range(0, 1)) add_byte(CHAR_NUL);
         c = plain_byte();
         x ^= c;
         add_byte(c);
         if ($urandom_range(0, 24) == 0) add_byte(CHAR_CR);
      end
      if (sel != 5) begin
         add_byte(CHAR_STAR);
         if (sel == 4) x ^= 8'($urandom_range(1, 255));
         case (sel)
            6: begin
               if ($urandom_range(0, 1)) begin
                  add_byte(hex_char(x[7:4], lower));
               end else begin
                  do begin
                     c = plain_byte();
                  end while (digit_value(c) != 5'b0_0000);
                  if ($urandom_range(0, 1)) add_byte(hex_char(x[7:4], lower));
                  add_byte(c);
                  if ($urandom_range(0, 1)) add_byte(hex_char(x[3:0], lower));
               end
            end
            7: begin
               add_byte(hex_char(x[7:4], lower));
               if ($urandom_range(0, 1)) add_byte(CHAR_NUL);
               add_byte(hex_char(x[3:0], lower));
            end
            default: begin
               add_byte(hex_char(x[7:4], lower));
               add_byte(hex_char(x[3:0], 1'($urandom_range(0, 1))));
            end
         endcase
         if (sel == 8) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               do begin
                  c = 8'($urandom_range(0, 255));
               end while (c == CHAR_DOLLAR || c == CHAR_LF);
               add_byte(c);
            end
         end
      end
      if ($urandom_range(0, 1)) add_byte(CHAR_CR);
      add_byte(CHAR_LF);
   endtask

   // Sample both handshakes, predict, check, and watch for a hang.
   always @(posedge clock) begin
      result_type r;
      result_type want;
      req_xfer = !reset && req_push && !req_full;
      rsp_xfer = !reset && rsp_pop && !rsp_empty;
      if (req_xfer && frame_byte(req_rx_byte, r)) expected_sentences.push_back(r);
      if (rsp_xfer) begin
         if (expected_sentences.size() == 0) begin
            $error("result with no sentence pending: sentence_length %0d",
                   rsp_sentence_length);
            fail_count++;
         end else begin
            want = expected_sentences.pop_front();
            if (rsp_sentence_length !== want.sentence_length) begin
               $error("sentence_length: expected %0d, got %0d",
                      want.sentence_length, rsp_sentence_length);
               fail_count++;
            end
            if (rsp_sum_present !== want.sum_present) begin
               $error("sum_present: expected %0d, got %0d",
                      want.sum_present, rsp_sum_present);
               fail_count++;
            end
            if (rsp_sum_match !== want.sum_match) begin
               $error("sum_match: expected %0d, got %0d",
                      want.sum_match, rsp_sum_match);
               fail_count++;
            end
         end
      end
      if (reset || req_xfer || rsp_xfer) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Byte driver: holds each byte until its transfer, then waits its drawn gap.
   always @(negedge clock) begin
      logic       next_push;
      logic [7:0] next_byte;
      stream_byte_type s;
      next_push = req_push;
      next_byte = req_rx_byte;
      if (reset) begin
         next_push = 1'b0;
      end else if (!req_push || req_xfer) begin
         next_push = 1'b0;
         if (req_xfer) tx_gap = draw_gap(tx_burst);
         if (tx_gap > 0) begin
            tx_gap--;
         end else if (byte_stream.size() > 0 &&
                      !(byte_stream[0].drain_first && expected_sentences.size() != 0)) begin
            s = byte_stream.pop_front();
            next_byte = s.b;
            next_push = 1'b1;
         end
      end
      req_push    <= next_push;
      req_rx_byte <= next_byte;
   end

   // Result receiver; once early on it holds off long enough to fill the block.
   always @(negedge clock) begin
      logic next_pop;
      if (reset) begin
         next_pop = 1'b0;
      end else begin
         if (rsp_xfer) begin
            rsp_count++;
            rx_gap = draw_gap(rx_burst);
            if (rsp_count == 12) rx_hold = RX_HOLD_LEN;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            next_pop = 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            next_pop = 1'b0;
         end else begin
            next_pop = 1'b1;
         end
      end
      rsp_pop <= next_pop;
   end

   initial begin
      // Directed: LF and a byte while idle, CR, an all-zero checksum,
      // lowercase digits, a restart by dollar with a zero byte before the
      // star, and a zero byte among the digits.
      add_byte(CHAR_LF);
      add_byte(8'hFF);
      add_byte(CHAR_DOLLAR); add_byte(CHAR_STAR); add_byte(8'h30); add_byte(8'h30);
      add_byte(CHAR_CR); add_byte(CHAR_LF);
      add_byte(CHAR_DOLLAR); add_byte(8'h4A); add_byte(CHAR_STAR); add_byte(8'h34);
      add_byte(8'h61); add_byte(CHAR_LF);
      add_byte(CHAR_DOLLAR); add_byte(CHAR_DOLLAR); add_byte(CHAR_NUL);
      add_byte(CHAR_STAR); add_byte(CHAR_LF);
      add_byte(CHAR_DOLLAR); add_byte(CHAR_STAR); add_byte(8'h46); add_byte(CHAR_NUL);
      add_byte(CHAR_LF);
      stream_total = 0;
      add_sentence(1'b1);
      while (stream_total < RANDOM_BYTES) add_sentence($urandom_range(0, 59) == 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (byte_stream.size() != 0 || req_push) @(posedge clock);
      while (expected_sentences.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
